@@ hw/rtl/gsvt_pkg.sv @@
// ---------------------------------------------------------------------------
// gsvt_pkg: shared types and constants
// Scan record, write record and sizes for the satellite group table.
// ---------------------------------------------------------------------------
package gsvt_pkg;

   localparam int GsvtEntries = 8;
   localparam int RecsPerPart = 4;
   localparam int IdxW        = 5;     // index width for up to 32 entries
   localparam int TotW        = 11;
   localparam logic [TotW-1:0] TotMax = 11'd2047;

   localparam logic [1:0] STAT_PENDING = 2'd0;
   localparam logic [1:0] STAT_DROPPED = 2'd1;
   localparam logic [1:0] STAT_SAVED   = 2'd2;

   // token that walks the row of entry cells
   typedef struct packed {
      logic            valid;
      logic            sum_mode;
      logic [23:0]     key_group;
      logic [31:0]     key_stamp;
      logic            match_hit;
      logic [IdxW-1:0] match_idx;
      logic            free_hit;
      logic [IdxW-1:0] free_idx;
      logic [IdxW-1:0] old_idx;
      logic [31:0]     old_dist;
      logic [TotW-1:0] lt;
      logic [TotW-1:0] vt;
      logic [TotW-1:0] kt;
      logic [TotW-1:0] tt;
   } scan_type;

   // entry write, broadcast to all cells
   typedef struct packed {
      logic            en;
      logic [IdxW-1:0] slot;
      logic [23:0]     group;
      logic [7:0]      locked;
      logic [7:0]      visible;
      logic [7:0]      known;
      logic [31:0]     stamp;
   } wr_type;

   function automatic logic [TotW-1:0] sat_add(logic [TotW-1:0] a, logic [7:0] b);
      logic [TotW:0] s;
      s = {1'b0, a} + {{(TotW-7){1'b0}}, b};
      return s[TotW] ? TotMax : s[TotW-1:0];
   endfunction

endpackage

@@ hw/rtl/gsvt_if.sv @@
// ---------------------------------------------------------------------------
// gsvt_req_if / gsvt_rsp_if: request and response channels
// Valid/ready handshake carrying the sentence fields and the table results.
// ---------------------------------------------------------------------------
interface gsvt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] talker_id;
   logic [7:0]  part_total;
   logic [7:0]  part_number;
   logic [7:0]  sats_known;
   logic [3:0]  elev_present;
   logic [3:0]  azim_present;
   logic [3:0]  strength_present;
   logic [7:0]  signal_id;
   logic [31:0] timestamp;
   modport source (output valid, talker_id, part_total, part_number, sats_known,
                   elev_present, azim_present, strength_present, signal_id,
                   timestamp, input ready);
   modport sink   (input valid, talker_id, part_total, part_number, sats_known,
                   elev_present, azim_present, strength_present, signal_id,
                   timestamp, output ready);
endinterface

interface gsvt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [2:0]  saved_slot;
   logic [10:0] locked_total;
   logic [10:0] visible_total;
   logic [10:0] known_total;
   logic [10:0] tracked_total;
   logic        totals_changed;
   modport source (output valid, status, saved_slot, locked_total, visible_total,
                   known_total, tracked_total, totals_changed, input ready);
   modport sink   (input valid, status, saved_slot, locked_total, visible_total,
                   known_total, tracked_total, totals_changed, output ready);
endinterface

@@ hw/rtl/gsvt_cell.sv @@
// ---------------------------------------------------------------------------
// gsvt_cell: one table entry
// Holds an entry, updates the passing scan token and hands it on.
// ---------------------------------------------------------------------------
module gsvt_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  gsvt_pkg::scan_type scan_in,
   input  gsvt_pkg::wr_type   wr,
   output gsvt_pkg::scan_type scan_out
);
   import gsvt_pkg::*;

   localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

   logic [23:0] group_ff;
   logic [7:0]  locked_ff, visible_ff, known_ff;
   logic [31:0] stamp_ff;
   scan_type    scan_ff, scan_in_nx;
   logic [31:0] age;
   logic        used;
   logic        wr_hit;
   logic [23:0] cur_group;
   logic [7:0]  cur_locked, cur_visible, cur_known;

   // entry storage
   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff   <= '0;
         locked_ff  <= '0;
         visible_ff <= '0;
         known_ff   <= '0;
         stamp_ff   <= '0;
      end else if (wr.en && wr.slot == MyIdx) begin
         group_ff   <= wr.group;
         locked_ff  <= wr.locked;
         visible_ff <= wr.visible;
         known_ff   <= wr.known;
         stamp_ff   <= wr.stamp;
      end
   end

   // token update: search or sum
   always_comb begin
      // a write landing this cycle is seen by the passing token
      wr_hit      = wr.en && (wr.slot == MyIdx);
      cur_group   = wr_hit ? wr.group   : group_ff;
      cur_locked  = wr_hit ? wr.locked  : locked_ff;
      cur_visible = wr_hit ? wr.visible : visible_ff;
      cur_known   = wr_hit ? wr.known   : known_ff;
      scan_in_nx  = scan_in;
      age         = scan_in.key_stamp - stamp_ff;
      used        = (cur_group != '0);
      if (scan_in.sum_mode) begin
         if (used) begin
            scan_in_nx.lt = sat_add(scan_in.lt, cur_locked);
            scan_in_nx.vt = sat_add(scan_in.vt, cur_visible);
            scan_in_nx.kt = sat_add(scan_in.kt, cur_known);
            if (cur_group[7:0] != '0) scan_in_nx.tt = sat_add(scan_in.tt, cur_visible);
         end
      end else begin
         if (!scan_in.free_hit && !used) begin
            scan_in_nx.free_hit = 1'b1;
            scan_in_nx.free_idx = MyIdx;
         end
         if (!scan_in.match_hit && cur_group == scan_in.key_group) begin
            scan_in_nx.match_hit = 1'b1;
            scan_in_nx.match_idx = MyIdx;
         end
         if (IDX == 0 || age > scan_in.old_dist) begin
            scan_in_nx.old_idx  = MyIdx;
            scan_in_nx.old_dist = age;
         end
      end
   end

   // hand token to neighbor
   always_ff @(posedge clock) begin
      if (reset) scan_ff.valid <= 1'b0;
      else       scan_ff.valid <= scan_in.valid;
      scan_ff.sum_mode  <= scan_in_nx.sum_mode;
      scan_ff.key_group <= scan_in_nx.key_group;
      scan_ff.key_stamp <= scan_in_nx.key_stamp;
      scan_ff.match_hit <= scan_in_nx.match_hit;
      scan_ff.match_idx <= scan_in_nx.match_idx;
      scan_ff.free_hit  <= scan_in_nx.free_hit;
      scan_ff.free_idx  <= scan_in_nx.free_idx;
      scan_ff.old_idx   <= scan_in_nx.old_idx;
      scan_ff.old_dist  <= scan_in_nx.old_dist;
      scan_ff.lt        <= scan_in_nx.lt;
      scan_ff.vt        <= scan_in_nx.vt;
      scan_ff.kt        <= scan_in_nx.kt;
      scan_ff.tt        <= scan_in_nx.tt;
   end

   assign scan_out = scan_ff;

endmodule

@@ hw/rtl/gsv_satellite_group_table.sv @@
// Sequence: from accept to response valid, a saved final part takes a search
//   walk, a write and a sum walk; pending or dropped parts take the sum walk.
// Flow: one request at a time; next accepted after the response is taken.
//   Each request waits for the token walking the row of entry cells.
// Reset: synchronous, active high; clears pending group, table, prev totals.
module gsv_satellite_group_table #(
   parameter int TABLE_ENTRIES = gsvt_pkg::GsvtEntries
) (
   input logic         clock,
   input logic         reset,
   gsvt_req_if.sink    req_if,
   gsvt_rsp_if.source  rsp_if
);
   import gsvt_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CALC   = 6'b000010,
      S_SEARCH = 6'b000100,
      S_WRITE  = 6'b001000,
      S_SUM    = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   // captured request
   logic [23:0] r_group_ff;
   logic [7:0]  r_total_ff, r_num_ff, r_known_ff;
   logic [3:0]  r_elev_ff, r_azim_ff, r_str_ff;
   logic [31:0] r_stamp_ff;
   // pending group; holds no stamp, the entry takes the final part's stamp
   logic [23:0] p_group_ff;
   logic [7:0]  p_locked_ff, p_visible_ff, p_known_ff, p_last_ff, p_total_ff;
   // results
   wr_type      wr_ff;
   logic [1:0]  status_ff;
   logic [IdxW-1:0] slot_ff;
   logic [4*TotW-1:0] prev_ff;
   logic        rsp_valid_ff;
   logic [TotW-1:0] lt_ff, vt_ff, kt_ff, tt_ff;
   logic        chg_ff;

   scan_type    launch;
   scan_type    chain [TABLE_ENTRIES+1];
   scan_type    tail;

   logic        final_part, bad;
   logic [2:0]  nrec;
   logic [7:0]  nlock, nvis;
   logic [23:0] n_group;
   logic [7:0]  n_known, n_locked, n_visible;

   // record counts and sequence check on captured request
   always_comb begin
      final_part = (r_num_ff == r_total_ff);
      nrec = 3'(RecsPerPart);
      if (final_part && r_known_ff[1:0] != 2'd0) nrec = {1'b0, r_known_ff[1:0]};
      nlock = '0;
      nvis  = '0;
      for (int i = 0; i < RecsPerPart; i++) begin
         if (3'(i) < nrec && r_str_ff[i]) begin
            nvis = nvis + 8'd1;
            if (r_elev_ff[i] && r_azim_ff[i]) nlock = nlock + 8'd1;
         end
      end
      bad = (r_num_ff > 8'd1) &&
            (({1'b0, r_num_ff} != {1'b0, p_last_ff} + 9'd1) || r_total_ff != p_total_ff ||
             r_group_ff != p_group_ff || r_known_ff != p_known_ff);
      n_group   = (r_num_ff == 8'd1) ? r_group_ff : p_group_ff;
      n_known   = (r_num_ff == 8'd1) ? r_known_ff : p_known_ff;
      n_locked  = ((r_num_ff == 8'd1) ? 8'd0 : p_locked_ff) + nlock;
      n_visible = ((r_num_ff == 8'd1) ? 8'd0 : p_visible_ff) + nvis;
   end

   // token launched into the cell row
   always_comb begin
      launch = '0;
      launch.key_group = wr_ff.group;
      launch.key_stamp = wr_ff.stamp;
      if (state_ff == S_CALC) begin
         launch.valid     = 1'b1;
         launch.sum_mode  = bad || !final_part;
         launch.key_group = n_group;
         launch.key_stamp = r_stamp_ff;
      end else if (state_ff == S_WRITE) begin
         launch.valid    = 1'b1;
         launch.sum_mode = 1'b1;
      end
   end

   assign chain[0] = launch;
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      gsvt_cell #(.IDX(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .scan_in  (chain[g]),
         .wr       (wr_ff),
         .scan_out (chain[g+1])
      );
   end
   assign tail = chain[TABLE_ENTRIES];

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_if.valid) state_in = S_CALC;
         S_CALC:   state_in = (bad || !final_part) ? S_SUM : S_SEARCH;
         S_SEARCH: if (tail.valid) state_in = S_WRITE;
         S_WRITE:  state_in = S_SUM;
         S_SUM:    if (tail.valid) state_in = S_OUT;
         S_OUT:    if (rsp_if.ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         wr_ff.en     <= 1'b0;
         p_group_ff   <= '0;
         p_locked_ff  <= '0;
         p_visible_ff <= '0;
         p_known_ff   <= '0;
         p_last_ff    <= '0;
         p_total_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wr_ff.en <= 1'b0;
         // pending group update
         if (state_ff == S_CALC) begin
            if (!bad) begin
               if (final_part) begin
                  p_group_ff   <= '0;
                  p_locked_ff  <= '0;
                  p_visible_ff <= '0;
                  p_known_ff   <= '0;
                  p_last_ff    <= '0;
                  p_total_ff   <= '0;
               end else begin
                  p_group_ff   <= n_group;
                  p_known_ff   <= n_known;
                  p_locked_ff  <= n_locked;
                  p_visible_ff <= n_visible;
                  p_last_ff    <= r_num_ff;
                  p_total_ff   <= r_total_ff;
               end
            end
         end
         if (state_ff == S_SEARCH && tail.valid) wr_ff.en <= 1'b1;
         // totals at end of sum walk
         if (state_ff == S_SUM && tail.valid) begin
            rsp_valid_ff <= 1'b1;
            prev_ff      <= {tail.tt, tail.kt, tail.vt, tail.lt};
         end else if (state_ff == S_OUT && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_if.valid) begin
         r_group_ff <= {req_if.talker_id, req_if.signal_id};
         r_total_ff <= req_if.part_total;
         r_num_ff   <= req_if.part_number;
         r_known_ff <= req_if.sats_known;
         r_elev_ff  <= req_if.elev_present;
         r_azim_ff  <= req_if.azim_present;
         r_str_ff   <= req_if.strength_present;
         r_stamp_ff <= req_if.timestamp;
      end
      if (state_ff == S_CALC) begin
         status_ff     <= bad ? STAT_DROPPED : (final_part ? STAT_SAVED : STAT_PENDING);
         slot_ff       <= '0;
         wr_ff.group   <= n_group;
         wr_ff.locked  <= n_locked;
         wr_ff.visible <= n_visible;
         wr_ff.known   <= n_known;
         wr_ff.stamp   <= r_stamp_ff;
      end
      if (state_ff == S_SEARCH && tail.valid) begin
         wr_ff.slot <= tail.match_hit ? tail.match_idx :
                       tail.free_hit  ? tail.free_idx  : tail.old_idx;
         slot_ff    <= tail.match_hit ? tail.match_idx :
                       tail.free_hit  ? tail.free_idx  : tail.old_idx;
      end
      if (state_ff == S_SUM && tail.valid) begin
         lt_ff  <= tail.lt;
         vt_ff  <= tail.vt;
         kt_ff  <= tail.kt;
         tt_ff  <= tail.tt;
         chg_ff <= ({tail.tt, tail.kt, tail.vt, tail.lt} != prev_ff);
      end
   end

   assign req_if.ready          = (state_ff == S_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.saved_slot     = 3'(slot_ff);
   assign rsp_if.locked_total   = lt_ff;
   assign rsp_if.visible_total  = vt_ff;
   assign rsp_if.known_total    = kt_ff;
   assign rsp_if.tracked_total  = tt_ff;
   assign rsp_if.totals_changed = chg_ff;

endmodule

@@ hw/rtl/gsvt_checker.sv @@
// ---------------------------------------------------------------------------
// gsvt_checker: port-level checks for the satellite group table
// Watches handshakes and response codes over time.
// ---------------------------------------------------------------------------
module gsvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_slot
);
   import gsvt_pkg::*;

   // response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request in flight: no new request while a response is shown
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   // a response follows an accepted request only after the cell walk
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response too early");

   // slot only reported for a saved group
   a_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_SAVED |-> rsp_slot == 3'd0)
      else $error("slot reported without save");

   // status code range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_PENDING || rsp_status == STAT_DROPPED ||
                     rsp_status == STAT_SAVED))
      else $error("bad status");

endmodule

bind gsv_satellite_group_table gsvt_checker u_gsvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_status (rsp_if.status),
   .rsp_slot   (rsp_if.saved_slot)
);
